>>> design/fcp_pkg.sv
// Shared types, constants and the CRC-16/CCITT-FALSE byte step for the frame parser.
package fcp_pkg;

  // Frame layout
  localparam int FRAME_BYTES = 21;
  localparam int POS_W       = 5;
  localparam int AXES        = 6;
  localparam int AXIS_FIRST  = 7;
  localparam int CRC_LO_AT   = 19;

  typedef logic [POS_W-1:0] pos_t;

  localparam pos_t POS_HUNT  = 5'd0;
  localparam pos_t POS_SYNC  = 5'd1;
  localparam pos_t POS_BODY  = 5'd2;
  localparam pos_t CRC_LAST  = 5'd18;
  localparam pos_t POS_LAST  = 5'(FRAME_BYTES - 1);

  // Bytes 0..19 are kept; the last byte is checked straight off the input
  typedef logic [7:0] frame_t [FRAME_BYTES-1];

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes
  localparam logic [2:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [2:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [2:0] CFG_VERSION       = 3'd2;
  localparam logic [2:0] CFG_TYPE          = 3'd3;
  localparam logic [2:0] CFG_LENGTH        = 3'd4;
  localparam logic [2:0] CFG_AXIS_LIMIT    = 3'd5;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_HDR  = 2'd1,
    ST_BAD_CRC  = 2'd2,
    ST_BAD_AXIS = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0]  header_first;
    logic [7:0]  header_second;
    logic [7:0]  expected_version;
    logic [7:0]  expected_type;
    logic [7:0]  expected_length;
    logic [14:0] axis_limit;
  } cfg_t;

  typedef struct packed {
    status_t              status;
    logic                 enabled;
    logic [7:0]           sequence_number;
    logic [AXES-1:0][15:0] axis;
  } result_t;

  // One byte through the MSB-first CRC, eight shifts unrolled
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

>>> design/fcp_check.sv
// Frame checks on the last byte: header fields, CRC compare, axis range, result fields.
module fcp_check (
  input  fcp_pkg::cfg_t    cfg,
  input  fcp_pkg::frame_t  frame,
  input  logic [7:0]       last_byte,
  input  logic [15:0]      crc,
  output fcp_pkg::result_t res
);
  import fcp_pkg::*;

  logic [AXES-1:0][15:0] axis;
  logic [AXES-1:0]       axis_ok;
  logic signed [16:0]    lim;
  logic [15:0]           crc_rx;
  logic                  hdr_ok;

  // Gather little-endian axes and range-check each one
  always_comb begin
    lim = $signed({2'b00, cfg.axis_limit});
    for (int i = 0; i < AXES; i++) begin
      axis[i]    = {frame[AXIS_FIRST + 2*i + 1], frame[AXIS_FIRST + 2*i]};
      axis_ok[i] = ($signed({axis[i][15], axis[i]}) <= lim) &&
                   ($signed({axis[i][15], axis[i]}) >= -lim);
    end
  end

  assign crc_rx = {last_byte, frame[CRC_LO_AT]};
  assign hdr_ok = (frame[2] == cfg.expected_version) &&
                  (frame[3] == cfg.expected_type) &&
                  (frame[5] == cfg.expected_length);

  // Pick status by priority and zero the fields of a rejected frame
  always_comb begin
    if (!hdr_ok) begin
      res.status = ST_BAD_HDR;
    end else if (crc_rx != crc) begin
      res.status = ST_BAD_CRC;
    end else if (!(&axis_ok)) begin
      res.status = ST_BAD_AXIS;
    end else begin
      res.status = ST_GOOD;
    end
    if (res.status == ST_GOOD) begin
      res.enabled         = frame[6][0];
      res.sequence_number = frame[4];
      res.axis            = axis;
    end else begin
      res.enabled         = 1'b0;
      res.sequence_number = 8'h00;
      res.axis            = '0;
    end
  end

endmodule

>>> design/framed_command_parser_crc16.sv
// Top level: byte hunter, frame store, running CRC, counters and result register.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_ready     rx_byte
//   out      output     out_valid / out_ready   frame_status .. bad_count
//   cfg      input      cfg_we (no wait)        cfg_index, cfg_data
//
// One byte per cycle unless stalled; each beat is handled in the cycle it is taken,
// and the last byte of a frame loads the result register, shown from the next cycle on.
// The sole limit is the single result register: input stalls only while a result
// waits and out_ready is low.
// Reset (synchronous, rst high) returns to hunting, clears counters and restores
// register defaults; no clearing pass is needed.
module framed_command_parser_crc16 (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         frame_status,
  output logic               enabled_flag,
  output logic [7:0]         sequence_number,
  output logic signed [15:0] roll_axis,
  output logic signed [15:0] pitch_axis,
  output logic signed [15:0] yaw_axis,
  output logic signed [15:0] heave_axis,
  output logic signed [15:0] forward_axis,
  output logic signed [15:0] lateral_axis,
  output logic [31:0]        good_count,
  output logic [31:0]        bad_count,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [14:0]        cfg_data
);
  import fcp_pkg::*;

  cfg_t        cfg;
  pos_t        pos;
  pos_t        pos_next;
  logic [15:0] crc;
  logic [15:0] crc_next;
  frame_t      frame_store;
  logic        store_we;
  logic        frame_done;
  logic        in_fire;
  result_t     res;
  result_t     result;
  logic [31:0] accepted_frames;
  logic [31:0] rejected_frames;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Write configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first     <= 8'hAA;
      cfg.header_second    <= 8'h55;
      cfg.expected_version <= 8'h01;
      cfg.expected_type    <= 8'h01;
      cfg.expected_length  <= 8'd13;
      cfg.axis_limit       <= 15'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HEADER_FIRST:  cfg.header_first     <= cfg_data[7:0];
        CFG_HEADER_SECOND: cfg.header_second    <= cfg_data[7:0];
        CFG_VERSION:       cfg.expected_version <= cfg_data[7:0];
        CFG_TYPE:          cfg.expected_type    <= cfg_data[7:0];
        CFG_LENGTH:        cfg.expected_length  <= cfg_data[7:0];
        CFG_AXIS_LIMIT:    cfg.axis_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hunt for the header, then advance through the body
  always_comb begin
    pos_next   = pos;
    crc_next   = crc;
    store_we   = 1'b0;
    frame_done = 1'b0;
    if (pos == POS_HUNT) begin
      if (rx_byte == cfg.header_first) begin
        pos_next = POS_SYNC;
      end
    end else if (pos == POS_SYNC) begin
      if (rx_byte == cfg.header_second) begin
        pos_next = POS_BODY;
        crc_next = CRC_INIT;
      end else if (rx_byte != cfg.header_first) begin
        pos_next = POS_HUNT;
      end
    end else if (pos > POS_LAST) begin
      pos_next = POS_HUNT;
    end else begin
      if (pos <= CRC_LAST) begin
        crc_next = crc16_step(crc, rx_byte);
      end
      if (pos == POS_LAST) begin
        pos_next   = POS_HUNT;
        frame_done = 1'b1;
      end else begin
        store_we = 1'b1;
        pos_next = pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= POS_HUNT;
      crc <= CRC_INIT;
    end else if (in_fire) begin
      pos <= pos_next;
      crc <= crc_next;
    end
  end

  // Store body bytes up to the CRC low byte
  always_ff @(posedge clk) begin
    if (in_fire && store_we) begin
      frame_store[pos] <= rx_byte;
    end
  end

  fcp_check u_check (
    .cfg       (cfg),
    .frame     (frame_store),
    .last_byte (rx_byte),
    .crc       (crc),
    .res       (res)
  );

  // Count frames; counters change only when a result loads
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_frames <= 32'd0;
      rejected_frames <= 32'd0;
    end else if (in_fire && frame_done) begin
      if (res.status == ST_GOOD) begin
        accepted_frames <= accepted_frames + 32'd1;
      end else begin
        rejected_frames <= rejected_frames + 32'd1;
      end
    end
  end

  // Result register: load on frame end, drop when the beat is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && frame_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && frame_done) begin
      result <= res;
    end
  end

  assign frame_status    = result.status;
  assign enabled_flag    = result.enabled;
  assign sequence_number = result.sequence_number;
  assign roll_axis       = $signed(result.axis[0]);
  assign pitch_axis      = $signed(result.axis[1]);
  assign yaw_axis        = $signed(result.axis[2]);
  assign heave_axis      = $signed(result.axis[3]);
  assign forward_axis    = $signed(result.axis[4]);
  assign lateral_axis    = $signed(result.axis[5]);
  assign good_count      = accepted_frames;
  assign bad_count       = rejected_frames;

  // Position never runs past the last frame byte
  a_pos_range: assert property (@(posedge clk) disable iff (rst) pos <= POS_LAST)
    else $error("byte position out of range");

  // Input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without a pending result");

  // Every completed frame bumps exactly one counter by one
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_done) |=>
      (32'(good_count + bad_count) == 32'($past(good_count) + $past(bad_count) + 32'd1)))
    else $error("frame counters out of step");

  // A rejected frame reports zero fields
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && result.status != ST_GOOD) |->
      (!enabled_flag && sequence_number == 8'h00 && result.axis == '0))
    else $error("rejected frame carries data");

  // A good frame bumps the good counter by one
  a_good_count: assert property (@(posedge clk) disable iff (rst)
    (in_fire && frame_done && res.status == ST_GOOD) |=>
      (good_count == 32'($past(good_count) + 32'd1)))
    else $error("good frame not counted");

endmodule

>>> tb/sv/tb_framed_command_parser_crc16.sv
// Self-checking testbench for the framed command parser with CRC-16 frame check.
module tb_framed_command_parser_crc16;
  import fcp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_FRAMES = 3;

  // Byte offsets inside a frame
  localparam int AT_VERSION = 2;
  localparam int AT_TYPE    = 3;
  localparam int AT_SEQ     = 4;
  localparam int AT_LENGTH  = 5;
  localparam int AT_FLAGS   = 6;

  // Indexes past the register file; the block must ignore them
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    status_t               status;
    logic                  enabled;
    logic [7:0]            seq;
    logic [AXES-1:0][15:0] axes;
    logic [31:0]           good;
    logic [31:0]           bad;
  } frame_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  frame_status;
  logic        enabled_flag;
  logic [7:0]  sequence_number;
  logic signed [15:0] roll_axis, pitch_axis, yaw_axis;
  logic signed [15:0] heave_axis, forward_axis, lateral_axis;
  logic [31:0] good_count, bad_count;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [14:0] cfg_data = 15'd0;

  framed_command_parser_crc16 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .frame_status(frame_status), .enabled_flag(enabled_flag),
    .sequence_number(sequence_number),
    .roll_axis(roll_axis), .pitch_axis(pitch_axis), .yaw_axis(yaw_axis),
    .heave_axis(heave_axis), .forward_axis(forward_axis), .lateral_axis(lateral_axis),
    .good_count(good_count), .bad_count(bad_count),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Parser mirror: registers, hunt position, frame bytes, CRC and counters
  logic [7:0]  hdr_first = 8'hAA;
  logic [7:0]  hdr_second = 8'h55;
  logic [7:0]  want_version = 8'd1;
  logic [7:0]  want_type = 8'd1;
  logic [7:0]  want_length = 8'd13;
  logic [14:0] axis_lim = 15'd1000;
  pos_t        scan_pos = POS_HUNT;
  logic [7:0]  rx_frame [FRAME_BYTES];
  logic [15:0] frame_crc = 16'hFFFF;
  logic [31:0] good_total = 32'd0;
  logic [31:0] bad_total = 32'd0;

  frame_report_t pending_reports [$];
  logic [7:0]    rx_backlog [$];
  logic [7:0]    frame_img [FRAME_BYTES];
  int            errors = 0;

  string axis_names [AXES] = '{"roll_axis", "pitch_axis", "yaw_axis",
                               "heave_axis", "forward_axis", "lateral_axis"};

  // CRC-16/CCITT-FALSE, one input bit per shift
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] b);
    logic fb;
    for (int k = 7; k >= 0; k--) begin
      fb  = crc[15] ^ b[k];
      crc = {crc[14:0], 1'b0} ^ (fb ? 16'h1021 : 16'h0000);
    end
    return crc;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [14:0] data);
    case (idx)
      CFG_HEADER_FIRST:  hdr_first = data[7:0];
      CFG_HEADER_SECOND: hdr_second = data[7:0];
      CFG_VERSION:       want_version = data[7:0];
      CFG_TYPE:          want_type = data[7:0];
      CFG_LENGTH:        want_length = data[7:0];
      CFG_AXIS_LIMIT:    axis_lim = data;
      default: ;
    endcase
  endfunction

  // Decide status for a completed frame and queue the report it must produce
  function automatic void judge_frame();
    frame_report_t rep;
    logic signed [15:0] s;
    int v;
    int lim;
    rep = '0;
    lim = int'(axis_lim);
    if (rx_frame[AT_VERSION] != want_version || rx_frame[AT_TYPE] != want_type ||
        rx_frame[AT_LENGTH] != want_length) begin
      rep.status = ST_BAD_HDR;
    end else if ({rx_frame[CRC_LO_AT+1], rx_frame[CRC_LO_AT]} != frame_crc) begin
      rep.status = ST_BAD_CRC;
    end else begin
      rep.status = ST_GOOD;
      for (int i = 0; i < AXES; i++) begin
        s = {rx_frame[AXIS_FIRST+2*i+1], rx_frame[AXIS_FIRST+2*i]};
        v = int'(s);
        if (v > lim || v < -lim) rep.status = ST_BAD_AXIS;
      end
    end
    if (rep.status == ST_GOOD) begin
      good_total++;
      rep.enabled = rx_frame[AT_FLAGS][0];
      rep.seq = rx_frame[AT_SEQ];
      for (int i = 0; i < AXES; i++)
        rep.axes[i] = {rx_frame[AXIS_FIRST+2*i+1], rx_frame[AXIS_FIRST+2*i]};
    end else begin
      bad_total++;
    end
    rep.good = good_total;
    rep.bad = bad_total;
    pending_reports.push_back(rep);
  endfunction

  // Advance the hunt / collect state by one received byte
  function automatic void parse_rx_byte(logic [7:0] b);
    case (scan_pos)
      POS_HUNT: begin
        if (b == hdr_first) begin
          rx_frame[0] = b;
          scan_pos = POS_SYNC;
        end
      end
      POS_SYNC: begin
        if (b == hdr_second) begin
          rx_frame[1] = b;
          scan_pos = POS_BODY;
          frame_crc = 16'hFFFF;
        end else if (b != hdr_first) begin
          scan_pos = POS_HUNT;
        end
      end
      default: begin
        rx_frame[scan_pos] = b;
        if (scan_pos <= CRC_LAST) frame_crc = crc_feed(frame_crc, b);
        if (scan_pos == POS_LAST) begin
          scan_pos = POS_HUNT;
          judge_frame();
        end else begin
          scan_pos = scan_pos + 5'd1;
        end
      end
    endcase
  endfunction

  // Byte driver: one beat per item, random gaps with quiet stretches
  int send_wait = 0;
  int send_mode_left = 0;
  bit send_quiet = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) parse_rx_byte(rx_byte);
      if (cfg_we) apply_reg(cfg_index, cfg_data);
      if (!in_valid || in_ready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (rx_backlog.size() > 0) begin
          in_valid <= 1'b1;
          rx_byte <= rx_backlog.pop_front();
          if (send_mode_left == 0) begin
            send_quiet = ($urandom_range(0, 2) == 0);
            send_mode_left = $urandom_range(10, 60);
          end
          send_mode_left--;
          send_wait = send_quiet ? 0 : $urandom_range(0, 12);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void check_report();
    frame_report_t want;
    logic [AXES-1:0][15:0] seen_ax;
    if (pending_reports.size() == 0) begin
      $error("result beat with no frame outstanding");
      errors++;
      return;
    end
    want = pending_reports.pop_front();
    seen_ax = {lateral_axis, forward_axis, heave_axis, yaw_axis, pitch_axis, roll_axis};
    check_field("frame_status", 32'(want.status), 32'(frame_status));
    check_field("enabled_flag", 32'(want.enabled), 32'(enabled_flag));
    check_field("sequence_number", 32'(want.seq), 32'(sequence_number));
    for (int i = 0; i < AXES; i++)
      check_field(axis_names[i], 32'(want.axes[i]), 32'(seen_ax[i]));
    check_field("good_count", want.good, good_count);
    check_field("bad_count", want.bad, bad_count);
  endfunction

  // Result monitor: check each beat, then stall a random number of cycles
  int recv_wait = 0;
  int recv_mode_left = 0;
  bit recv_quiet = 0;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      check_report();
      if (recv_mode_left == 0) begin
        recv_quiet = ($urandom_range(0, 2) == 0);
        recv_mode_left = $urandom_range(3, 12);
      end
      recv_mode_left--;
      recv_wait = recv_quiet ? 0 : $urandom_range(0, 12);
    end else if (recv_wait > 0) begin
      recv_wait--;
    end
    out_ready <= (recv_wait == 0);
  end

  // Watchdog
  int cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_framed_command_parser_crc16 failed");
      $finish;
    end
  end

  // Stimulus helpers; all run from the negative edge
  task automatic drain();
    while (rx_backlog.size() != 0 || in_valid || pending_reports.size() != 0)
      @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [14:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic build_frame(logic [7:0] ver, logic [7:0] typ, logic [7:0] seq,
                             logic [7:0] len, logic [7:0] flags,
                             logic [AXES-1:0][15:0] ax, logic [15:0] crc_flip);
    logic [15:0] c;
    frame_img[0] = hdr_first;
    frame_img[1] = hdr_second;
    frame_img[AT_VERSION] = ver;
    frame_img[AT_TYPE] = typ;
    frame_img[AT_SEQ] = seq;
    frame_img[AT_LENGTH] = len;
    frame_img[AT_FLAGS] = flags;
    for (int i = 0; i < AXES; i++) begin
      frame_img[AXIS_FIRST+2*i] = ax[i][7:0];
      frame_img[AXIS_FIRST+2*i+1] = ax[i][15:8];
    end
    c = 16'hFFFF;
    for (int k = POS_BODY; k <= CRC_LAST; k++) c = crc_feed(c, frame_img[k]);
    c ^= crc_flip;
    frame_img[CRC_LO_AT] = c[7:0];
    frame_img[CRC_LO_AT+1] = c[15:8];
  endtask

  task automatic push_bytes(int first, int last);
    for (int k = first; k <= last; k++) rx_backlog.push_back(frame_img[k]);
  endtask

  task automatic push_frame(logic [7:0] ver, logic [7:0] typ, logic [7:0] seq,
                            logic [7:0] len, logic [7:0] flags,
                            logic [AXES-1:0][15:0] ax, logic [15:0] crc_flip);
    build_frame(ver, typ, seq, len, flags, ax, crc_flip);
    push_bytes(0, FRAME_BYTES - 1);
  endtask

  function automatic logic [15:0] axis_inside();
    int lim;
    int v;
    lim = int'(axis_lim);
    case ($urandom_range(0, 5))
      0: v = lim;
      1: v = -lim;
      default: v = int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    return 16'(v);
  endfunction

  function automatic logic [15:0] axis_outside();
    int lim;
    int v;
    lim = int'(axis_lim);
    if (lim == 32767 || $urandom_range(0, 1) == 0) v = -int'($urandom_range(lim + 1, 32768));
    else v = int'($urandom_range(lim + 1, 32767));
    return 16'(v);
  endfunction

  // Mostly well-formed frames, plus bad fields, noise and broken sequences
  task automatic push_random_frame();
    int kind;
    int n;
    logic [7:0] ver, typ, len, b;
    logic [AXES-1:0][15:0] ax;
    logic [15:0] flip;
    kind = $urandom_range(0, 19);
    ver = want_version;
    typ = want_type;
    len = want_length;
    flip = 16'h0000;
    for (int i = 0; i < AXES; i++) ax[i] = axis_inside();
    case (kind)
      10, 11: ax[$urandom_range(0, AXES - 1)] = axis_outside();
      12: begin
        case ($urandom_range(0, 2))
          0: ver ^= 8'($urandom_range(1, 255));
          1: typ ^= 8'($urandom_range(1, 255));
          default: len ^= 8'($urandom_range(1, 255));
        endcase
      end
      13: flip = 16'($urandom_range(1, 65535));
      14: begin
        // line noise only
        n = $urandom_range(1, 8);
        repeat (n) rx_backlog.push_back(8'($urandom_range(0, 255)));
        return;
      end
      15: begin
        // cut-off frame: later bytes land in its body
        build_frame(ver, typ, 8'($urandom), len, 8'($urandom), ax, flip);
        push_bytes(0, $urandom_range(2, FRAME_BYTES - 2));
        return;
      end
      16: repeat ($urandom_range(1, 3)) rx_backlog.push_back(hdr_first);
      17: begin
        do b = 8'($urandom_range(0, 255)); while (b == hdr_first || b == hdr_second);
        rx_backlog.push_back(hdr_first);
        rx_backlog.push_back(b);
      end
      18: for (int i = 0; i < AXES; i++) ax[i] = 16'($urandom_range(0, 65535));
      19: begin
        ver = 8'($urandom);
        typ = 8'($urandom);
        len = 8'($urandom);
      end
      default: ;
    endcase
    push_frame(ver, typ, 8'($urandom), len, 8'($urandom), ax, flip);
  endtask

  task automatic random_frames();
    repeat (RANDOM_FRAMES) push_random_frame();
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Defaults: wrong second header, repeated first header, then edge axes
    rx_backlog.push_back(hdr_first);
    rx_backlog.push_back(8'h12);
    rx_backlog.push_back(hdr_first);
    rx_backlog.push_back(hdr_first);
    push_frame(want_version, want_type, 8'h00, want_length, 8'hFF,
               {16'h0001, 16'hFFFF, 16'h0000, 16'hFC18, 16'h03E8, 16'h01F4}, 16'h0000);
    push_frame(want_version, want_type, 8'hFF, want_length, 8'hFE,
               {16'hFC18, 16'h03E8, 16'h0000, 16'h0000, 16'hFC18, 16'h03E8}, 16'h0000);
    // Rejected frames of every kind
    push_frame(8'h00, want_type, 8'h11, want_length, 8'h01, '0, 16'h0000);
    push_frame(want_version, 8'hFF, 8'h22, want_length, 8'h01, '0, 16'h0000);
    push_frame(want_version, want_type, 8'h33, 8'h00, 8'h01, '0, 16'h0000);
    push_frame(want_version, want_type, 8'h44, want_length, 8'h01, '0, 16'h8000);
    push_frame(want_version, want_type, 8'h55, want_length, 8'h01,
               {16'h0, 16'h0, 16'h0, 16'h0, 16'h8000, 16'h7FFF}, 16'h0000);
    push_frame(want_version, want_type, 8'h66, want_length, 8'h01,
               {16'h03E9, 16'h0, 16'h0, 16'h0, 16'h0, 16'h0}, 16'h0000);
    push_frame(want_version, want_type, 8'h77, want_length, 8'h01,
               {16'h0, 16'h0, 16'hFC17, 16'h0, 16'h0, 16'h0}, 16'h0000);
    drain();

    // Register change in the middle of a frame applies to its check
    build_frame(want_version, 8'h42, 8'h88, want_length, 8'h01, '0, 16'h0000);
    push_bytes(0, 9);
    drain();
    write_reg(CFG_TYPE, 15'h0042);
    push_bytes(10, FRAME_BYTES - 1);
    drain();
    write_reg(CFG_TYPE, 15'h0001);
    random_frames();

    // Extremes: zero limit allows only zero axes
    write_reg(CFG_HEADER_FIRST, 15'h0000);
    write_reg(CFG_HEADER_SECOND, 15'h00FF);
    write_reg(CFG_VERSION, 15'h00FF);
    write_reg(CFG_TYPE, 15'h0000);
    write_reg(CFG_LENGTH, 15'h00FF);
    write_reg(CFG_AXIS_LIMIT, 15'h0000);
    random_frames();

    // Equal header bytes, full limit; upper data bits must be dropped
    write_reg(CFG_HEADER_FIRST, 15'h7F7E);
    write_reg(CFG_HEADER_SECOND, 15'h5A7E);
    write_reg(CFG_VERSION, 15'h7F00);
    write_reg(CFG_TYPE, 15'h00FF);
    write_reg(CFG_LENGTH, 15'h4000);
    write_reg(CFG_AXIS_LIMIT, 15'h7FFF);
    write_reg(CFG_SPARE_LO, 15'h7FFF);
    write_reg(CFG_SPARE_HI, 15'h0000);
    rx_backlog.push_back(hdr_first);
    push_frame(want_version, want_type, 8'h5A, want_length, 8'h01,
               {16'h7FFF, 16'h8001, 16'h0, 16'h0, 16'h0, 16'h0}, 16'h0000);
    push_frame(want_version, want_type, 8'hA5, want_length, 8'h01,
               {16'h0, 16'h0, 16'h8000, 16'h0, 16'h0, 16'h0}, 16'h0000);
    random_frames();

    // Random settings, twice
    repeat (2) begin
      write_reg(CFG_HEADER_FIRST, 15'($urandom));
      write_reg(CFG_HEADER_SECOND, 15'($urandom));
      write_reg(CFG_VERSION, 15'($urandom));
      write_reg(CFG_TYPE, 15'($urandom));
      write_reg(CFG_LENGTH, 15'($urandom));
      write_reg(CFG_AXIS_LIMIT, 15'($urandom));
      write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, 15'($urandom));
      random_frames();
    end

    // Back to defaults for a last stretch
    write_reg(CFG_HEADER_FIRST, 15'h00AA);
    write_reg(CFG_HEADER_SECOND, 15'h0055);
    write_reg(CFG_VERSION, 15'h0001);
    write_reg(CFG_TYPE, 15'h0001);
    write_reg(CFG_LENGTH, 15'h000D);
    write_reg(CFG_AXIS_LIMIT, 15'd1000);
    random_frames();

    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("tb_framed_command_parser_crc16 passed");
    end else begin
      $display("tb_framed_command_parser_crc16 failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/fcp_pkg.sv
design/fcp_check.sv
design/framed_command_parser_crc16.sv
tb/sv/tb_framed_command_parser_crc16.sv
